### sv/ssgs_pkg.sv
// Shared widths, codes and types of the sixteen-step gate sequencer.
package ssgs_pkg;

  // Field widths of the input and result beats
  localparam int BTN_W       = 5;
  localparam int GBTN_W      = 16;
  localparam int PHASE_IN_W  = 24;
  localparam int LEN_IN_W    = 5;
  localparam int WADDR_W     = 6;
  localparam int VALUE_W     = 12;
  localparam int GATES_W     = 16;
  localparam int STEP_OUT_W  = 4;
  localparam int OUT_ROWS    = 3;

  // Configuration port
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int GATE_MODE_W = 2;
  localparam int PULSE_W     = 16;
  localparam logic [PULSE_W-1:0] PULSE_RESET = 16'd48;

  localparam logic [CFG_IDX_W-1:0] REG_GATE_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LEN = 1'b1;

  // Item kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Button bit positions in button_levels
  localparam int BTN_RUN  = 0;
  localparam int BTN_RST  = 1;
  localparam int BTN_PREV = 2;
  localparam int BTN_NEXT = 3;
  localparam int BTN_EDIT = 4;

  typedef enum logic [GATE_MODE_W-1:0] {
    GATE_TRIG   = 2'd0,
    GATE_RETRIG = 2'd1,
    GATE_CONT   = 2'd2
  } gate_mode_e;

  // Tick fields handed to the control logic
  typedef struct packed {
    logic [BTN_W-1:0]      button_levels;
    logic                  ext_clock_present;
    logic                  ext_clock_level;
    logic [PHASE_IN_W-1:0] phase_increment;
    logic [LEN_IN_W-1:0]   advance_length;
    logic [LEN_IN_W-1:0]   knob_length;
    logic [GBTN_W-1:0]     gate_button_levels;
  } tick_t;

  // Control part of one result beat
  typedef struct packed {
    logic [GATES_W-1:0]    step_gates;
    logic                  common_gate;
    logic [STEP_OUT_W-1:0] current_step;
    logic                  is_running;
    logic                  edit_active;
  } result_t;

  typedef logic [OUT_ROWS-1:0][VALUE_W-1:0] row_vals_t;

endpackage

### sv/ssgs_in_if.sv
// Input channel of the sequencer: tick and row-store write beats.
interface ssgs_in_if;
  import ssgs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [BTN_W-1:0]      button_levels;
  logic                  ext_clock_present;
  logic                  ext_clock_level;
  logic [PHASE_IN_W-1:0] phase_increment;
  logic [LEN_IN_W-1:0]   advance_length;
  logic [LEN_IN_W-1:0]   knob_length;
  logic [GBTN_W-1:0]     gate_button_levels;
  logic [WADDR_W-1:0]    write_address;
  logic [VALUE_W-1:0]    write_value;

  modport source (
    output valid, kind, button_levels, ext_clock_present, ext_clock_level,
           phase_increment, advance_length, knob_length, gate_button_levels,
           write_address, write_value,
    input  ready
  );

  modport sink (
    input  valid, kind, button_levels, ext_clock_present, ext_clock_level,
           phase_increment, advance_length, knob_length, gate_button_levels,
           write_address, write_value,
    output ready
  );
endinterface

### sv/ssgs_out_if.sv
// Result channel of the sequencer: one beat per tick.
interface ssgs_out_if;
  import ssgs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [GATES_W-1:0]    step_gates;
  logic                  common_gate;
  logic [VALUE_W-1:0]    row_one_value;
  logic [VALUE_W-1:0]    row_two_value;
  logic [VALUE_W-1:0]    row_three_value;
  logic [STEP_OUT_W-1:0] current_step;
  logic                  is_running;
  logic                  edit_active;

  modport source (
    output valid, step_gates, common_gate, row_one_value, row_two_value,
           row_three_value, current_step, is_running, edit_active,
    input  ready
  );

  modport sink (
    input  valid, step_gates, common_gate, row_one_value, row_two_value,
           row_three_value, current_step, is_running, edit_active,
    output ready
  );
endinterface

### sv/ssgs_ctrl.sv
// Per-tick control: edge detection, run/edit flags, clocking, step and gates.
module ssgs_ctrl #(
  parameter  int STEP_COUNT          = 16,
  parameter  int PHASE_FRACTION_BITS = 24,
  localparam int IDX_W               = $clog2(STEP_COUNT)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ssgs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ssgs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                         tick_en_i,
  input  ssgs_pkg::tick_t              tick_i,
  output ssgs_pkg::result_t            res_o,
  output logic [IDX_W-1:0]             shown_o
);
  import ssgs_pkg::*;

  localparam int LEN_W = $clog2(STEP_COUNT + 1);
  localparam int GB_N  = (STEP_COUNT < GBTN_W) ? STEP_COUNT : GBTN_W;
  localparam int PF    = PHASE_FRACTION_BITS;

  // Configuration and state registers
  logic [GATE_MODE_W-1:0] gate_mode_q;
  logic [PULSE_W-1:0]     pulse_len_q;
  logic                   run_q, run_d;
  logic                   edit_q, edit_d;
  logic [IDX_W-1:0]       step_q, step_d;
  logic [PF-1:0]          phase_q, phase_d;
  logic [PULSE_W-1:0]     pulse_q, pulse_d;
  logic [STEP_COUNT-1:0]  pattern_q, pattern_d;
  logic [BTN_W-1:0]       prev_btn_q, prev_btn_d;
  logic                   prev_clk_q, prev_clk_d;
  logic [GBTN_W-1:0]      prev_gbtn_q, prev_gbtn_d;

  // Intermediate values of one tick
  logic [BTN_W-1:0]            bedge;
  logic [GBTN_W-1:0]           gedge;
  logic                        clk_edge;
  logic                        run1, adv, cont, pulse, common_pre, edit1, run2;
  logic [PF+PHASE_IN_W-1:0]    phase_inc_pad;
  logic [PF:0]                 phase_sum;
  logic [LEN_W-1:0]            len_a, len_k;
  logic [IDX_W:0]              inc1, inc2;
  logic [IDX_W-1:0]            step1, step_pv;
  logic [PULSE_W-1:0]          pulse_ld;
  logic [GATES_W-1:0]          gates;
  logic [IDX_W+STEP_OUT_W-1:0] step_pad;

  // Length knob saturated to 1..STEP_COUNT
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_IN_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (32'(v) > STEP_COUNT) begin
      r = LEN_W'(STEP_COUNT);
    end else begin
      r = LEN_W'(v);
    end
    return r;
  endfunction

  assign bedge    = tick_i.button_levels & ~prev_btn_q;
  assign gedge    = tick_i.gate_button_levels & ~prev_gbtn_q;
  assign clk_edge = tick_i.ext_clock_level & ~prev_clk_q;
  assign len_a    = clamp_len(tick_i.advance_length);
  assign len_k    = clamp_len(tick_i.knob_length);

  assign phase_inc_pad = {{PF{1'b0}}, tick_i.phase_increment};
  assign phase_sum     = {1'b0, phase_q} + {1'b0, phase_inc_pad[PF-1:0]};
  assign inc1          = {1'b0, step_q} + {{IDX_W{1'b0}}, 1'b1};

  // Run toggle, clocking and step advance
  always_comb begin
    run1       = run_q ^ bedge[BTN_RUN];
    adv        = 1'b0;
    phase_d    = phase_q;
    prev_clk_d = prev_clk_q;
    if (run1) begin
      if (tick_i.ext_clock_present) begin
        if (clk_edge) begin
          phase_d = '0;
          adv     = 1'b1;
        end
        prev_clk_d = tick_i.ext_clock_level;
      end else begin
        phase_d = phase_sum[PF-1:0];
        adv     = phase_sum[PF];
      end
    end
    // reset edge restarts the phase and lands on step 0
    if (bedge[BTN_RST]) begin
      phase_d = '0;
      adv     = 1'b1;
    end

    step1    = step_q;
    pulse_ld = pulse_q;
    if (adv) begin
      if (bedge[BTN_RST] || 32'(inc1) >= 32'(len_a)) begin
        step1 = '0;
      end else begin
        step1 = inc1[IDX_W-1:0];
      end
      if (pulse_len_q > pulse_q) begin
        pulse_ld = pulse_len_q;
      end
    end
    pulse   = (pulse_ld != '0);
    pulse_d = pulse ? pulse_ld - 1'b1 : pulse_ld;
  end

  // Gate pattern toggles and gate shaping
  always_comb begin
    pattern_d = pattern_q;
    for (int i = 0; i < GB_N; i++) begin
      pattern_d[i] = pattern_q[i] ^ gedge[i];
    end
    prev_gbtn_d = tick_i.gate_button_levels;

    cont = run1 && pattern_d[step1];
    case (gate_mode_q)
      GATE_TRIG:   common_pre = cont && pulse;
      GATE_RETRIG: common_pre = cont && !pulse;
      default:     common_pre = cont;
    endcase

    gates = '0;
    if (common_pre && 32'(step1) < GATES_W) begin
      gates = GATES_W'(1) << step1;
    end
  end

  // Edit mode, then prev/next while stopped
  always_comb begin
    edit1 = run1 ? 1'b0 : edit_q;
    if (bedge[BTN_EDIT]) begin
      edit1 = ~edit1;
    end
    run2 = edit1 ? 1'b0 : run1;

    prev_btn_d           = prev_btn_q;
    prev_btn_d[BTN_RUN]  = tick_i.button_levels[BTN_RUN];
    prev_btn_d[BTN_RST]  = tick_i.button_levels[BTN_RST];
    prev_btn_d[BTN_EDIT] = tick_i.button_levels[BTN_EDIT];

    step_pv = step1;
    step_d  = step1;
    inc2    = {1'b0, step1} + {{IDX_W{1'b0}}, 1'b1};
    if (!run2) begin
      if (bedge[BTN_PREV]) begin
        step_pv = (step1 == '0) ? IDX_W'(len_k - 1'b1) : step1 - 1'b1;
      end
      inc2   = {1'b0, step_pv} + {{IDX_W{1'b0}}, 1'b1};
      step_d = step_pv;
      if (bedge[BTN_NEXT]) begin
        step_d = (32'(inc2) >= 32'(len_k)) ? '0 : inc2[IDX_W-1:0];
      end
      prev_btn_d[BTN_PREV] = tick_i.button_levels[BTN_PREV];
      prev_btn_d[BTN_NEXT] = tick_i.button_levels[BTN_NEXT];
    end
    run_d  = run2;
    edit_d = edit1;
  end

  assign step_pad           = {{STEP_OUT_W{1'b0}}, step_d};
  assign res_o.step_gates   = gates;
  assign res_o.common_gate  = common_pre | edit1;
  assign res_o.current_step = step_pad[STEP_OUT_W-1:0];
  assign res_o.is_running   = run_d;
  assign res_o.edit_active  = edit_d;
  assign shown_o            = step1;

  // Configuration and state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_mode_q <= GATE_TRIG;
      pulse_len_q <= PULSE_RESET;
      run_q       <= 1'b1;
      edit_q      <= 1'b0;
      step_q      <= '0;
      phase_q     <= '0;
      pulse_q     <= '0;
      pattern_q   <= '1;
      prev_btn_q  <= '0;
      prev_clk_q  <= 1'b0;
      prev_gbtn_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GATE_MODE: gate_mode_q <= cfg_wdata_i[GATE_MODE_W-1:0];
          REG_PULSE_LEN: pulse_len_q <= cfg_wdata_i[PULSE_W-1:0];
          default: ;
        endcase
      end
      if (tick_en_i) begin
        run_q       <= run_d;
        edit_q      <= edit_d;
        step_q      <= step_d;
        phase_q     <= phase_d;
        pulse_q     <= pulse_d;
        pattern_q   <= pattern_d;
        prev_btn_q  <= prev_btn_d;
        prev_clk_q  <= prev_clk_d;
        prev_gbtn_q <= prev_gbtn_d;
      end
    end
  end

endmodule

### sv/ssgs_row_store.sv
// Row value store: one memory word per step holding every row, registered read.
module ssgs_row_store #(
  parameter  int STEP_COUNT = 16,
  parameter  int ROW_COUNT  = 3,
  parameter  int VALUE_BITS = 12,
  localparam int IDX_W      = $clog2(STEP_COUNT)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [ssgs_pkg::WADDR_W-1:0]  wr_addr_i,
  input  logic [ssgs_pkg::VALUE_W-1:0]  wr_value_i,
  input  logic                          rd_en_i,
  input  logic [IDX_W-1:0]              rd_step_i,
  output ssgs_pkg::row_vals_t           rd_rows_o
);
  import ssgs_pkg::*;

  localparam int ROW_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

  logic [VALUE_BITS-1:0]                 mem_q [STEP_COUNT][ROW_COUNT];
  logic [STEP_COUNT-1:0][ROW_COUNT-1:0]  vld_q;
  logic [VALUE_BITS-1:0]                 rd_q [ROW_COUNT];
  logic [ROW_COUNT-1:0]                  rd_vld_q;

  logic                        wr_hit;
  logic [ROW_W-1:0]            wr_row;
  logic [IDX_W-1:0]            wr_step;
  logic [VALUE_BITS+VALUE_W-1:0] wr_pad;

  // Split the flat address into row and step; out-of-range writes are dropped
  always_comb begin
    wr_hit  = 1'b0;
    wr_row  = '0;
    wr_step = '0;
    for (int r = 0; r < ROW_COUNT; r++) begin
      if (32'(wr_addr_i) >= r * STEP_COUNT && 32'(wr_addr_i) < (r + 1) * STEP_COUNT) begin
        wr_hit  = 1'b1;
        wr_row  = ROW_W'(r);
        wr_step = IDX_W'(32'(wr_addr_i) - r * STEP_COUNT);
      end
    end
  end

  assign wr_pad = {{VALUE_BITS{1'b0}}, wr_value_i};

  // Memory array: lane write, whole-word registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_hit) begin
      mem_q[wr_step][wr_row] <= wr_pad[VALUE_BITS-1:0];
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_step_i];
    end
  end

  // Written marks stand in for the zero reset of the store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= '0;
    end else begin
      if (wr_en_i && wr_hit) begin
        vld_q[wr_step][wr_row] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_step_i];
      end
    end
  end

  // Result lanes; missing rows read zero
  for (genvar k = 0; k < OUT_ROWS; k++) begin : g_lane
    if (k < ROW_COUNT) begin : g_row
      logic [VALUE_W+VALUE_BITS-1:0] rd_pad;
      assign rd_pad       = {{VALUE_W{1'b0}}, rd_q[k]};
      assign rd_rows_o[k] = rd_vld_q[k] ? rd_pad[VALUE_W-1:0] : '0;
    end else begin : g_none
      assign rd_rows_o[k] = '0;
    end
  end

endmodule

### sv/sixteen_step_gate_sequencer_core.sv
// Top level of the sixteen-step gate sequencer: control, row store and output stage.
//
//  channel  dir  handshake     beat contents
//  in_i     in   valid/ready   tick (buttons, clocks, lengths) or row-store write
//  out_o    out  valid/ready   gates, common gate, three row values, step, flags
//  cfg      in   cfg_we_i      register index and write data, no wait
//
// One item is accepted every cycle while input ready is high; a tick's result
// passes through the registered read of the row store, then the output register.
// Write beats produce no result. Reset is asynchronous; the row store reads
// zero until written through per-entry written marks, so no clearing pass.
// A stalled result holds in the output register while one more tick waits in
// the read stage; input ready drops only when both are full.
module sixteen_step_gate_sequencer_core #(
  parameter int STEP_COUNT          = 16,
  parameter int ROW_COUNT           = 3,
  parameter int VALUE_BITS          = 12,
  parameter int PHASE_FRACTION_BITS = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ssgs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ssgs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  ssgs_in_if.sink                         in_i,
  ssgs_out_if.source                      out_o
);
  import ssgs_pkg::*;

  localparam int IDX_W = $clog2(STEP_COUNT);

  tick_t            tick;
  result_t          res_d;
  logic [IDX_W-1:0] shown;
  row_vals_t        rows;
  logic             in_acc, tick_acc, wr_acc, out_free;

  logic      s1_vld_q;
  result_t   s1_res_q;
  logic      out_vld_q;
  result_t   out_res_q;
  row_vals_t out_rows_q;

  assign tick.button_levels      = in_i.button_levels;
  assign tick.ext_clock_present  = in_i.ext_clock_present;
  assign tick.ext_clock_level    = in_i.ext_clock_level;
  assign tick.phase_increment    = in_i.phase_increment;
  assign tick.advance_length     = in_i.advance_length;
  assign tick.knob_length        = in_i.knob_length;
  assign tick.gate_button_levels = in_i.gate_button_levels;

  // Handshake: the read stage moves whenever the output register frees up
  assign out_free   = !out_vld_q || out_o.ready;
  assign in_i.ready = !s1_vld_q || out_free;
  assign in_acc     = in_i.valid && in_i.ready;
  assign tick_acc   = in_acc && (in_i.kind == KIND_TICK);
  assign wr_acc     = in_acc && (in_i.kind == KIND_WRITE);

  ssgs_ctrl #(
    .STEP_COUNT          (STEP_COUNT),
    .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tick_en_i   (tick_acc),
    .tick_i      (tick),
    .res_o       (res_d),
    .shown_o     (shown)
  );

  // Row reads issue with the tick; a write lands before any later read
  ssgs_row_store #(
    .STEP_COUNT (STEP_COUNT),
    .ROW_COUNT  (ROW_COUNT),
    .VALUE_BITS (VALUE_BITS)
  ) u_row_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_acc),
    .wr_addr_i  (in_i.write_address),
    .wr_value_i (in_i.write_value),
    .rd_en_i    (tick_acc),
    .rd_step_i  (shown),
    .rd_rows_o  (rows)
  );

  // Pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (tick_acc) begin
        s1_vld_q <= 1'b1;
      end else if (out_free) begin
        s1_vld_q <= 1'b0;
      end
      if (out_free) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      s1_res_q <= res_d;
    end
    if (out_free && s1_vld_q) begin
      out_res_q  <= s1_res_q;
      out_rows_q <= rows;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.step_gates      = out_res_q.step_gates;
  assign out_o.common_gate     = out_res_q.common_gate;
  assign out_o.row_one_value   = out_rows_q[0];
  assign out_o.row_two_value   = out_rows_q[1];
  assign out_o.row_three_value = out_rows_q[2];
  assign out_o.current_step    = out_res_q.current_step;
  assign out_o.is_running      = out_res_q.is_running;
  assign out_o.edit_active     = out_res_q.edit_active;

endmodule

### tb/tb_top.sv
// Regression bench for the sixteen-step gate sequencer core: directed and random ticks.
`timescale 1ns / 1ps

module tb_top;
  import ssgs_pkg::*;

  // Bit positions in the packed level word used for edge detection
  localparam int CLK_BIT   = 5;
  localparam int GBTN_BASE = 6;
  localparam int STEPS     = 16;
  localparam logic [GATE_MODE_W-1:0] GATE_MODE_SPARE = 2'd3;

  typedef struct {
    logic                kind;
    tick_t               tk;
    logic [WADDR_W-1:0]  waddr;
    logic [VALUE_W-1:0]  wval;
  } seq_item_t;

  typedef struct {
    logic [GATES_W-1:0]    step_gates;
    logic                  common_gate;
    logic [VALUE_W-1:0]    row_one;
    logic [VALUE_W-1:0]    row_two;
    logic [VALUE_W-1:0]    row_three;
    logic [STEP_OUT_W-1:0] current_step;
    logic                  is_running;
    logic                  edit_active;
  } seq_out_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ssgs_in_if  in_ch ();
  ssgs_out_if out_ch ();

  sixteen_step_gate_sequencer_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // Sequencer state mirrored by the bench, at its reset values
  logic               seq_running  = 1'b1;
  logic               seq_edit     = 1'b0;
  int unsigned        seq_step     = 0;
  logic [23:0]        seq_phase    = '0;
  logic [PULSE_W-1:0] pulse_left   = '0;
  logic [15:0]        gate_pattern = 16'hFFFF;
  logic [21:0]        prev_levels  = '0;
  logic [VALUE_W-1:0] row_store [0:3*STEPS-1] = '{default: '0};
  logic [GATE_MODE_W-1:0] cfg_gate_mode = GATE_TRIG;
  logic [PULSE_W-1:0]     cfg_pulse_len = PULSE_RESET;

  seq_out_t    pending_beats[$];
  int unsigned error_count = 0;
  int unsigned beat_count  = 0;
  int unsigned items_sent  = 0;
  bit          in_fast  = 1'b0;
  bit          out_fast = 1'b0;
  bit          ext_sel  = 1'b0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("sixteen_step_gate_sequencer_core regression: fail");
    $finish;
  end

  function automatic int unsigned clamp_len(logic [LEN_IN_W-1:0] v);
    if (v == 0) return 1;
    if (v > STEPS) return STEPS;
    return v;
  endfunction

  // Advance the mirrored sequencer by one tick and form its result beat
  function automatic seq_out_t sequence_tick(tick_t t);
    logic [21:0] lv;
    logic        adv, pulse, on, gate;
    logic [24:0] acc;
    int unsigned len, shown;
    seq_out_t    r;
    lv  = {t.gate_button_levels, t.ext_clock_level, t.button_levels};
    adv = 1'b0;
    if (lv[BTN_RUN] && !prev_levels[BTN_RUN]) seq_running = !seq_running;
    prev_levels[BTN_RUN] = lv[BTN_RUN];
    // clock source: external edge or phase overflow
    if (seq_running) begin
      if (t.ext_clock_present) begin
        if (lv[CLK_BIT] && !prev_levels[CLK_BIT]) begin
          seq_phase = '0;
          adv = 1'b1;
        end
        prev_levels[CLK_BIT] = lv[CLK_BIT];
      end else begin
        acc = {1'b0, seq_phase} + {1'b0, t.phase_increment};
        adv = acc[24];
        seq_phase = acc[23:0];
      end
    end
    // reset forces an advance that lands on step 0
    if (lv[BTN_RST] && !prev_levels[BTN_RST]) begin
      seq_phase = '0;
      seq_step  = STEPS;
      adv       = 1'b1;
    end
    prev_levels[BTN_RST] = lv[BTN_RST];
    if (adv) begin
      len = clamp_len(t.advance_length);
      seq_step++;
      if (seq_step >= len) seq_step = 0;
      if (cfg_pulse_len > pulse_left) pulse_left = cfg_pulse_len;
    end
    pulse = (pulse_left != 0);
    if (pulse) pulse_left--;
    for (int i = 0; i < STEPS; i++) begin
      if (lv[GBTN_BASE+i] && !prev_levels[GBTN_BASE+i]) gate_pattern[i] = ~gate_pattern[i];
      prev_levels[GBTN_BASE+i] = lv[GBTN_BASE+i];
    end
    // gate shaping by mode; the spare mode acts as continuous
    on = seq_running && gate_pattern[seq_step];
    case (cfg_gate_mode)
      GATE_TRIG:   gate = on && pulse;
      GATE_RETRIG: gate = on && !pulse;
      default:     gate = on;
    endcase
    r.step_gates  = gate ? (16'd1 << seq_step) : '0;
    r.common_gate = gate;
    shown = seq_step;
    // edit mode
    if (seq_running) seq_edit = 1'b0;
    if (lv[BTN_EDIT] && !prev_levels[BTN_EDIT]) seq_edit = !seq_edit;
    prev_levels[BTN_EDIT] = lv[BTN_EDIT];
    if (seq_edit) begin
      seq_running   = 1'b0;
      r.common_gate = 1'b1;
    end
    // manual stepping while stopped
    if (!seq_running) begin
      len = clamp_len(t.knob_length);
      if (lv[BTN_PREV] && !prev_levels[BTN_PREV]) begin
        if (seq_step == 0) seq_step = len - 1;
        else seq_step--;
      end
      prev_levels[BTN_PREV] = lv[BTN_PREV];
      if (lv[BTN_NEXT] && !prev_levels[BTN_NEXT]) begin
        seq_step++;
        if (seq_step > len - 1) seq_step = 0;
      end
      prev_levels[BTN_NEXT] = lv[BTN_NEXT];
    end
    r.row_one      = row_store[shown];
    r.row_two      = row_store[STEPS + shown];
    r.row_three    = row_store[2*STEPS + shown];
    r.current_step = seq_step[3:0];
    r.is_running   = seq_running;
    r.edit_active  = seq_edit;
    return r;
  endfunction

  function automatic seq_item_t make_tick(logic [BTN_W-1:0] btn, logic present, logic level,
                                          logic [PHASE_IN_W-1:0] inc,
                                          logic [LEN_IN_W-1:0] alen, logic [LEN_IN_W-1:0] klen,
                                          logic [GBTN_W-1:0] gbtn);
    seq_item_t it;
    it.kind                  = KIND_TICK;
    it.tk.button_levels      = btn;
    it.tk.ext_clock_present  = present;
    it.tk.ext_clock_level    = level;
    it.tk.phase_increment    = inc;
    it.tk.advance_length     = alen;
    it.tk.knob_length        = klen;
    it.tk.gate_button_levels = gbtn;
    it.waddr = WADDR_W'($urandom);
    it.wval  = VALUE_W'($urandom);
    return it;
  endfunction

  function automatic seq_item_t make_write(logic [WADDR_W-1:0] addr, logic [VALUE_W-1:0] val);
    seq_item_t it;
    it       = make_tick(BTN_W'($urandom), 1'($urandom), 1'($urandom), PHASE_IN_W'($urandom),
                         LEN_IN_W'($urandom), LEN_IN_W'($urandom), GBTN_W'($urandom));
    it.kind  = KIND_WRITE;
    it.waddr = addr;
    it.wval  = val;
    return it;
  endfunction

  function automatic logic [LEN_IN_W-1:0] draw_len();
    if ($urandom_range(0, 7) == 0) return LEN_IN_W'($urandom_range(0, 31));
    return LEN_IN_W'($urandom_range(1, STEPS));
  endfunction

  // Tick with sparse button presses; bits in busy are pressed more often
  function automatic seq_item_t random_tick(logic [BTN_W-1:0] busy);
    logic [BTN_W-1:0]      btn;
    logic [GBTN_W-1:0]     gbtn;
    logic [PHASE_IN_W-1:0] inc;
    btn = '0;
    for (int b = 0; b < BTN_W; b++)
      btn[b] = busy[b] ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 39) == 0);
    gbtn = '0;
    for (int b = 0; b < GBTN_W; b++) gbtn[b] = ($urandom_range(0, 11) == 0);
    if ($urandom_range(0, 29) == 0) gbtn = GBTN_W'($urandom);
    case ($urandom_range(0, 4))
      0:       inc = PHASE_IN_W'($urandom_range(0, 255));
      1:       inc = 24'hFFFFFF - PHASE_IN_W'($urandom_range(0, 4095));
      2:       inc = 24'h800000 | PHASE_IN_W'($urandom);
      3:       inc = ($urandom_range(0, 1) == 0) ? 24'h000000 : 24'hFFFFFF;
      default: inc = PHASE_IN_W'($urandom);
    endcase
    return make_tick(btn, ext_sel, 1'($urandom), inc, draw_len(), draw_len(), gbtn);
  endfunction

  // Present one beat, wait for it to be taken, then update the mirror
  task automatic send_item(seq_item_t it);
    int unsigned gap;
    gap = in_fast ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.kind               <= it.kind;
    in_ch.button_levels      <= it.tk.button_levels;
    in_ch.ext_clock_present  <= it.tk.ext_clock_present;
    in_ch.ext_clock_level    <= it.tk.ext_clock_level;
    in_ch.phase_increment    <= it.tk.phase_increment;
    in_ch.advance_length     <= it.tk.advance_length;
    in_ch.knob_length        <= it.tk.knob_length;
    in_ch.gate_button_levels <= it.tk.gate_button_levels;
    in_ch.write_address      <= it.waddr;
    in_ch.write_value        <= it.wval;
    in_ch.valid              <= 1'b1;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
    if (it.kind == KIND_TICK) pending_beats.push_back(sequence_tick(it.tk));
    else if (it.waddr < 3*STEPS) row_store[it.waddr] = it.wval;
  endtask

  // Release every button, then press one
  task automatic press_button(int b);
    seq_item_t it;
    it = random_tick('0);
    it.tk.button_levels = '0;
    send_item(it);
    it = random_tick('0);
    it.tk.button_levels = BTN_W'(1 << b);
    send_item(it);
  endtask

  // Stop sending and let all outstanding beats come out
  task automatic drain_pending();
    in_ch.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_config(logic [GATE_MODE_W-1:0] mode, logic [PULSE_W-1:0] pulse);
    logic [CFG_DATA_W-1:0] word;
    drain_pending();
    // upper bits of the mode word carry junk, only the low bits count
    word = CFG_DATA_W'($urandom);
    word[GATE_MODE_W-1:0] = mode;
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_GATE_MODE;
    cfg_wdata <= word;
    @(posedge clk_i);
    cfg_gate_mode = mode;
    cfg_idx   <= REG_PULSE_LEN;
    cfg_wdata <= pulse;
    @(posedge clk_i);
    cfg_pulse_len = pulse;
    cfg_we <= 1'b0;
  endtask

  // Mismatch reporting
  task automatic report_mismatch(string msg);
    error_count++;
    $display("ERROR: %s", msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("beat %0d %s: got %h, expected %h", beat_count, name, got, want));
  endtask

  // Result sink: random stall before each beat
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = out_fast ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  // Compare each delivered beat with the oldest prediction
  always @(posedge clk_i) begin : check_beats
    seq_out_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("beat %0d arrived with nothing expected", beat_count));
      end else begin
        want = pending_beats.pop_front();
        check_field("step_gates", out_ch.step_gates, want.step_gates);
        check_field("common_gate", out_ch.common_gate, want.common_gate);
        check_field("row_one_value", out_ch.row_one_value, want.row_one);
        check_field("row_two_value", out_ch.row_two_value, want.row_two);
        check_field("row_three_value", out_ch.row_three_value, want.row_three);
        check_field("current_step", out_ch.current_step, want.current_step);
        check_field("is_running", out_ch.is_running, want.is_running);
        check_field("edit_active", out_ch.edit_active, want.edit_active);
      end
      beat_count++;
    end
  end

  // Quiet ticks straight out of reset
  task automatic test_reset_state();
    send_item(make_tick('0, 1'b0, 1'b0, '0, 5'd1, 5'd1, '0));
    send_item(make_tick('0, 1'b0, 1'b0, 24'd1, 5'd16, 5'd16, '0));
  endtask

  // Field extremes, both item kinds and the named corner cases
  task automatic test_directed_cases();
    send_item(make_write(6'd0, 12'hFFF));
    send_item(make_write(6'd47, 12'h800));
    send_item(make_write(6'd16, 12'h001));
    send_item(make_write(6'd48, 12'h123));   // beyond the store, dropped
    send_item(make_write(6'd63, 12'hFFF));   // beyond the store, dropped
    // phase wraps on the first max increment; zero length clamps to one
    send_item(make_tick('0, 1'b0, 1'b0, 24'hFFFFFF, 5'd0, 5'd1, '0));
    send_item(make_tick('0, 1'b0, 1'b0, 24'hFFFFFF, 5'd31, 5'd1, '0));
    send_item(make_tick(BTN_W'(1 << BTN_RST), 1'b0, 1'b0, '0, 5'd16, 5'd16, '0));
    // external clock edge, then the low level
    send_item(make_tick('0, 1'b1, 1'b1, '0, 5'd16, 5'd16, '0));
    send_item(make_tick('0, 1'b1, 1'b0, '0, 5'd16, 5'd16, '0));
    // every gate button at once
    send_item(make_tick('0, 1'b0, 1'b0, '0, 5'd16, 5'd16, 16'hFFFF));
    send_item(make_tick('0, 1'b0, 1'b0, '0, 5'd16, 5'd16, '0));
    // stop, then step by hand, including a step past a shorter knob length
    send_item(make_tick(BTN_W'(1 << BTN_RUN), 1'b0, 1'b0, '0, 5'd16, 5'd16, '0));
    send_item(make_tick(BTN_W'(1 << BTN_NEXT), 1'b0, 1'b0, '0, 5'd16, 5'd31, '0));
    send_item(make_tick('0, 1'b0, 1'b0, '0, 5'd16, 5'd16, '0));
    send_item(make_tick(BTN_W'(1 << BTN_NEXT), 1'b0, 1'b0, '0, 5'd16, 5'd16, '0));
    send_item(make_tick(BTN_W'(1 << BTN_PREV), 1'b0, 1'b0, '0, 5'd16, 5'd2, '0));
    send_item(make_tick(BTN_W'(1 << BTN_NEXT), 1'b0, 1'b0, '0, 5'd16, 5'd1, '0));
    send_item(make_tick(BTN_W'(1 << BTN_PREV), 1'b0, 1'b0, '0, 5'd16, 5'd0, '0));
    // edit on, a gate toggle while editing, edit off, run again
    send_item(make_tick(BTN_W'(1 << BTN_EDIT), 1'b0, 1'b0, '0, 5'd16, 5'd16, 16'h0020));
    send_item(make_tick('0, 1'b0, 1'b0, '0, 5'd16, 5'd16, '0));
    send_item(make_tick(BTN_W'(1 << BTN_EDIT), 1'b0, 1'b0, '0, 5'd16, 5'd16, '0));
    send_item(make_tick(BTN_W'(1 << BTN_RUN), 1'b0, 1'b0, '0, 5'd16, 5'd16, '0));
    send_item(make_tick(5'h1F, 1'b1, 1'b1, 24'hFFFFFF, 5'h1F, 5'h1F, 16'hFFFF));
    send_item(make_tick('0, 1'b0, 1'b0, '0, 5'd16, 5'd16, '0));
  endtask

  // One random stretch of stimulus of a chosen flavor
  task automatic run_sequence();
    int unsigned flavor, n;
    seq_item_t   it;
    if ($urandom_range(0, 3) == 0) in_fast = ~in_fast;
    if ($urandom_range(0, 3) == 0) out_fast = ~out_fast;
    if ($urandom_range(0, 2) == 0) ext_sel = ~ext_sel;
    flavor = $urandom_range(0, 99);
    if (flavor < 60) begin
      // running with the clock advancing the step
      if (!seq_running) press_button(BTN_RUN);
      n = $urandom_range(8, 24);
      repeat (n) send_item(random_tick(BTN_W'(1 << BTN_RST)));
    end else if (flavor < 75) begin
      // stopped, stepping by hand
      if (seq_running) press_button(BTN_RUN);
      n = $urandom_range(6, 16);
      repeat (n) send_item(random_tick(BTN_W'((1 << BTN_PREV) | (1 << BTN_NEXT))));
    end else if (flavor < 85) begin
      // edit session
      press_button(BTN_EDIT);
      n = $urandom_range(4, 10);
      repeat (n) send_item(random_tick(BTN_W'((1 << BTN_PREV) | (1 << BTN_NEXT))));
      press_button(BTN_EDIT);
    end else if (flavor < 95) begin
      // row store loads, a few past the end
      n = $urandom_range(2, 8);
      repeat (n) begin
        if ($urandom_range(0, 5) == 0)
          send_item(make_write(WADDR_W'($urandom_range(48, 63)), VALUE_W'($urandom)));
        else
          send_item(make_write(WADDR_W'($urandom_range(0, 47)), VALUE_W'($urandom)));
      end
    end else begin
      // raw noise
      n = $urandom_range(3, 8);
      repeat (n) begin
        it = make_write(WADDR_W'($urandom), VALUE_W'($urandom));
        it.kind = 1'($urandom);
        send_item(it);
      end
    end
  endtask

  // Random stimulus across gate modes and pulse lengths, extremes included
  task automatic test_random_phases();
    logic [GATE_MODE_W-1:0] modes  [9];
    logic [PULSE_W-1:0]     pulses [9];
    int unsigned            start;
    modes  = '{GATE_TRIG, GATE_RETRIG, GATE_CONT, GATE_MODE_SPARE, GATE_TRIG,
               GATE_RETRIG, GATE_CONT, GATE_TRIG, GATE_RETRIG};
    pulses = '{PULSE_RESET, 16'd1, 16'd0, 16'hFFFF, 16'd0,
               PULSE_W'($urandom), 16'd1, PULSE_W'($urandom_range(1, 8)), 16'hFFFF};
    for (int p = 0; p < 9; p++) begin
      load_config(modes[p], pulses[p]);
      start = items_sent;
      while (items_sent - start < 60) run_sequence();
    end
  endtask

  // Test flow
  initial begin
    rst_ni                   <= 1'b0;
    cfg_we                   <= 1'b0;
    cfg_idx                  <= REG_GATE_MODE;
    cfg_wdata                <= '0;
    in_ch.valid              <= 1'b0;
    in_ch.kind               <= KIND_TICK;
    in_ch.button_levels      <= '0;
    in_ch.ext_clock_present  <= 1'b0;
    in_ch.ext_clock_level    <= 1'b0;
    in_ch.phase_increment    <= '0;
    in_ch.advance_length     <= '0;
    in_ch.knob_length        <= '0;
    in_ch.gate_button_levels <= '0;
    in_ch.write_address      <= '0;
    in_ch.write_value        <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_directed_cases();
    test_random_phases();

    drain_pending();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("sixteen_step_gate_sequencer_core regression: pass");
    end else begin
      $display("sixteen_step_gate_sequencer_core regression: fail");
    end
    $finish;
  end

endmodule
